[rtl/core/jddm_pkg.sv]
// ----------------------------------------------------------------------------
// jddm_pkg
// shared types and constants of the joystick differential drive mixer
// ----------------------------------------------------------------------------
package jddm_pkg;

    localparam int DIV_W      = 16;
    localparam int DIV_STAGES = DIV_W;
    localparam int OUT_W      = 21;
    localparam int GMAG_W     = DIV_W + 13;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [7:0] FORCED_CENTRE = 8'h80;
    localparam logic [7:0] SPIN_CAP      = 8'd50;
    localparam logic [GMAG_W-1:0] OUT_POS_MAX = GMAG_W'(1048575);
    localparam logic [GMAG_W-1:0] OUT_NEG_MAX = GMAG_W'(1048576);

    typedef enum logic [2:0] {
        REG_ZERO_POINT   = 3'd0,
        REG_DEAD_BAND    = 3'd1,
        REG_TURN_DIVISOR = 3'd2,
        REG_SPIN_DIVISOR = 3'd3,
        REG_MIN_SCALAR   = 3'd4,
        REG_MAX_SCALAR   = 3'd5,
        REG_SPEED_GAIN   = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [7:0]  zero_point;
        logic [6:0]  dead_band;
        logic [7:0]  turn_divisor;
        logic [7:0]  spin_divisor;
        logic [7:0]  min_scalar;
        logic [7:0]  max_scalar;
        logic [12:0] speed_gain;
    } cfg_t;

    typedef struct packed {
        logic       x_right;
        logic       x_left;
        logic       y_out;
        logic       y_neg;
        logic [7:0] x_mag;
        logic [7:0] y_mag;
        logic [7:0] f_mag;
        logic       f_neg;
        logic [7:0] knob;
    } entry_t;

endpackage

[rtl/core/jddm_div.sv]
// ----------------------------------------------------------------------------
// jddm_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module jddm_div
    import jddm_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [DIV_W-1:0] dividend,
    input  logic [7:0]       divisor,
    output logic [DIV_W-1:0] quotient
);

    logic [7:0]       rem_reg  [DIV_STAGES];
    logic [DIV_W-1:0] work_reg [DIV_STAGES];
    logic [7:0]       rem_in   [DIV_STAGES];
    logic [DIV_W-1:0] work_in  [DIV_STAGES];
    logic [7:0]       rem_next [DIV_STAGES];
    logic [DIV_W-1:0] work_next[DIV_STAGES];
    logic [8:0]       trial    [DIV_STAGES];
    logic [8:0]       diff     [DIV_STAGES];
    logic             ge       [DIV_STAGES];

    always_comb
    begin
        rem_in[0]  = '0;
        work_in[0] = dividend;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            rem_in[k]  = rem_reg[k-1];
            work_in[k] = work_reg[k-1];
        end
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            trial[k]     = {rem_in[k], work_in[k][DIV_W-1]};
            ge[k]        = trial[k] >= {1'b0, divisor};
            diff[k]      = trial[k] - {1'b0, divisor};
            rem_next[k]  = ge[k] ? diff[k][7:0] : trial[k][7:0];
            work_next[k] = {work_in[k][DIV_W-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                work_reg[k] <= work_next[k];
            end
        end
    end

    assign quotient = work_reg[DIV_STAGES-1];

endmodule

[rtl/core/jddm_front.sv]
// ----------------------------------------------------------------------------
// jddm_front
// configuration registers and classification of joystick items
// ----------------------------------------------------------------------------
module jddm_front
    import jddm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic [7:0]  forward_back_axis,
    input  logic [7:0]  turn_axis,
    input  logic [7:0]  flipper_axis,
    input  logic [7:0]  speed_knob,
    input  logic        parking,
    input  logic        emergency_stop,
    input  logic        flipper_hold,
    output cfg_t        cfg,
    output entry_t      entry
);

    cfg_t cfg_reg;

    logic [7:0] x, y, z, k_lo;
    logic [8:0] hi;
    logic       x_above, x_below, y_above, y_below, z_above, z_below;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_point   <= 8'd128;
            cfg_reg.dead_band    <= 7'd10;
            cfg_reg.turn_divisor <= 8'd2;
            cfg_reg.spin_divisor <= 8'd1;
            cfg_reg.min_scalar   <= 8'd50;
            cfg_reg.max_scalar   <= 8'd255;
            cfg_reg.speed_gain   <= 13'd1;
        end
        else if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_ZERO_POINT:   cfg_reg.zero_point   <= cfg_data[7:0];
                REG_DEAD_BAND:    cfg_reg.dead_band    <= cfg_data[6:0];
                REG_TURN_DIVISOR: cfg_reg.turn_divisor <= cfg_data[7:0];
                REG_SPIN_DIVISOR: cfg_reg.spin_divisor <= cfg_data[7:0];
                REG_MIN_SCALAR:   cfg_reg.min_scalar   <= cfg_data[7:0];
                REG_MAX_SCALAR:   cfg_reg.max_scalar   <= cfg_data[7:0];
                REG_SPEED_GAIN:   cfg_reg.speed_gain   <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        x = (parking || emergency_stop) ? FORCED_CENTRE : turn_axis;
        y = (parking || emergency_stop) ? FORCED_CENTRE : forward_back_axis;
        z = flipper_hold ? FORCED_CENTRE : flipper_axis;

        hi      = {1'b0, cfg_reg.zero_point} + {2'b0, cfg_reg.dead_band};
        x_above = {1'b0, x} > hi;
        y_above = {1'b0, y} > hi;
        z_above = {1'b0, z} > hi;
        x_below = ({1'b0, x} + {2'b0, cfg_reg.dead_band}) < {1'b0, cfg_reg.zero_point};
        y_below = ({1'b0, y} + {2'b0, cfg_reg.dead_band}) < {1'b0, cfg_reg.zero_point};
        z_below = ({1'b0, z} + {2'b0, cfg_reg.dead_band}) < {1'b0, cfg_reg.zero_point};

        entry.x_right = x_above;
        entry.x_left  = x_below;
        entry.x_mag   = x_above ? (x - cfg_reg.zero_point)
                      : x_below ? (cfg_reg.zero_point - x) : 8'd0;
        entry.y_out   = y_above || y_below;
        entry.y_neg   = y_below;
        entry.y_mag   = y_below ? (cfg_reg.zero_point - y) : (y - cfg_reg.zero_point);
        entry.f_neg   = z_below;
        entry.f_mag   = z_above ? (z - cfg_reg.zero_point)
                      : z_below ? (cfg_reg.zero_point - z) : 8'd0;

        k_lo       = (speed_knob < cfg_reg.min_scalar) ? cfg_reg.min_scalar : speed_knob;
        entry.knob = (k_lo > cfg_reg.max_scalar) ? cfg_reg.max_scalar : k_lo;
    end

endmodule

[rtl/core/jddm_queue.sv]
// ----------------------------------------------------------------------------
// jddm_queue
// short item queue between the front and the back part
// ----------------------------------------------------------------------------
module jddm_queue
    import jddm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    input  logic   pop,
    output entry_t head,
    output logic   full,
    output logic   empty
);

    entry_t              mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign full  = count_reg == (QPTR_W+1)'(QDEPTH);
    assign empty = count_reg == '0;
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/core/jddm_back.sv]
// ----------------------------------------------------------------------------
// jddm_back
// turn and spin division, track mixing, knob scaling, gain and saturation
// ----------------------------------------------------------------------------
module jddm_back
    import jddm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     q_empty,
    input  entry_t                   q_head,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [OUT_W-1:0]  right_drive,
    output logic signed [OUT_W-1:0]  left_drive,
    output logic signed [OUT_W-1:0]  flipper_drive
);

    logic en;
    logic [7:0] turn_div, spin_div, max_div;

    logic   a_vld_reg [DIV_STAGES];
    entry_t a_side_reg[DIV_STAGES];
    logic   b_vld_reg [DIV_STAGES];
    entry_t b_side_reg[DIV_STAGES];
    logic [7:0] b_turn_reg[DIV_STAGES];
    logic   e_vld_reg [DIV_STAGES];
    logic [2:0] e_neg_reg[DIV_STAGES];

    logic [DIV_W-1:0] turn_q, spin_q, r_q, l_q, f_q;
    logic [7:0] turn, cap, spin_t, tl, tr, ml, mr, mag_r, mag_l;
    logic       neg_r, neg_l;
    entry_t     bs;

    logic             c_vld_reg;
    logic [DIV_W-1:0] c_r_reg, c_l_reg, c_f_reg;
    logic [2:0]       c_neg_reg;

    logic              g_vld_reg;
    logic [GMAG_W-1:0] g_r_reg, g_l_reg, g_f_reg;
    logic [2:0]        g_neg_reg;

    logic out_valid_reg;
    logic signed [OUT_W-1:0] right_reg, left_reg, flip_reg;

    function automatic logic [OUT_W-1:0] sat(input logic [GMAG_W-1:0] m, input logic neg);
        logic [GMAG_W-1:0] t;
        begin
            if (neg)
            begin
                t = (m > OUT_NEG_MAX) ? OUT_NEG_MAX : m;
                sat = OUT_W'(~t + 1'b1);
            end
            else
            begin
                sat = OUT_W'((m > OUT_POS_MAX) ? OUT_POS_MAX : m);
            end
        end
    endfunction

    assign en       = !out_valid_reg || out_ready;
    assign q_pop    = en && !q_empty;
    assign turn_div = (cfg.turn_divisor == 8'd0) ? 8'd1 : cfg.turn_divisor;
    assign spin_div = (cfg.spin_divisor == 8'd0) ? 8'd1 : cfg.spin_divisor;
    assign max_div  = (cfg.max_scalar == 8'd0) ? 8'd1 : cfg.max_scalar;

    jddm_div u_turn_div (
        .clk      (clk),
        .en       (en),
        .dividend ({8'd0, q_head.x_mag}),
        .divisor  (turn_div),
        .quotient (turn_q)
    );

    assign turn = turn_q[7:0];
    assign cap  = (turn > SPIN_CAP) ? SPIN_CAP : turn;

    jddm_div u_spin_div (
        .clk      (clk),
        .en       (en),
        .dividend ({8'd0, cap}),
        .divisor  (spin_div),
        .quotient (spin_q)
    );

    // track mixing
    always_comb
    begin
        bs     = b_side_reg[DIV_STAGES-1];
        spin_t = spin_q[7:0];
        tl     = bs.x_right ? b_turn_reg[DIV_STAGES-1] : 8'd0;
        tr     = bs.x_left  ? b_turn_reg[DIV_STAGES-1] : 8'd0;
        ml     = (bs.y_mag >= tl) ? (bs.y_mag - tl) : (tl - bs.y_mag);
        mr     = (bs.y_mag >= tr) ? (bs.y_mag - tr) : (tr - bs.y_mag);
        if (bs.y_out)
        begin
            mag_r = mr;
            neg_r = bs.y_neg;
            mag_l = ml;
            neg_l = !bs.y_neg;
        end
        else
        begin
            mag_r = (bs.x_right || bs.x_left) ? spin_t : 8'd0;
            neg_r = bs.x_right;
            mag_l = mag_r;
            neg_l = bs.x_right;
        end
    end

    jddm_div u_right_div (
        .clk      (clk),
        .en       (en),
        .dividend (c_r_reg),
        .divisor  (max_div),
        .quotient (r_q)
    );

    jddm_div u_left_div (
        .clk      (clk),
        .en       (en),
        .dividend (c_l_reg),
        .divisor  (max_div),
        .quotient (l_q)
    );

    jddm_div u_flip_div (
        .clk      (clk),
        .en       (en),
        .dividend (c_f_reg),
        .divisor  (max_div),
        .quotient (f_q)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg[0] <= q_head;
            b_side_reg[0] <= a_side_reg[DIV_STAGES-1];
            b_turn_reg[0] <= turn;
            e_neg_reg[0]  <= c_neg_reg;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                a_side_reg[k] <= a_side_reg[k-1];
                b_side_reg[k] <= b_side_reg[k-1];
                b_turn_reg[k] <= b_turn_reg[k-1];
                e_neg_reg[k]  <= e_neg_reg[k-1];
            end
            c_r_reg   <= DIV_W'(mag_r * bs.knob);
            c_l_reg   <= DIV_W'(mag_l * bs.knob);
            c_f_reg   <= DIV_W'(bs.f_mag * bs.knob);
            c_neg_reg <= {bs.f_neg, neg_l, neg_r};
            g_r_reg   <= GMAG_W'(r_q * cfg.speed_gain);
            g_l_reg   <= GMAG_W'(l_q * cfg.speed_gain);
            g_f_reg   <= GMAG_W'(f_q * cfg.speed_gain);
            g_neg_reg <= e_neg_reg[DIV_STAGES-1];
            right_reg <= sat(g_r_reg, g_neg_reg[0]);
            left_reg  <= sat(g_l_reg, g_neg_reg[1]);
            flip_reg  <= sat(g_f_reg, g_neg_reg[2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                a_vld_reg[k] <= 1'b0;
                b_vld_reg[k] <= 1'b0;
                e_vld_reg[k] <= 1'b0;
            end
            c_vld_reg     <= 1'b0;
            g_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg[0] <= !q_empty;
            b_vld_reg[0] <= a_vld_reg[DIV_STAGES-1];
            e_vld_reg[0] <= c_vld_reg;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                a_vld_reg[k] <= a_vld_reg[k-1];
                b_vld_reg[k] <= b_vld_reg[k-1];
                e_vld_reg[k] <= e_vld_reg[k-1];
            end
            c_vld_reg     <= b_vld_reg[DIV_STAGES-1];
            g_vld_reg     <= e_vld_reg[DIV_STAGES-1];
            out_valid_reg <= g_vld_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign right_drive   = right_reg;
    assign left_drive    = left_reg;
    assign flipper_drive = flip_reg;

endmodule

[rtl/core/joystick_differential_drive_mixer.sv]
// throughput: one item per cycle while out_ready does not stall the output, set by the fully pipelined dividers
// a stalled output holds the whole back pipeline; the 4-entry queue absorbs
// items until it fills, then in_ready drops
// reset: asynchronous active low, clears control state and loads register defaults
// ----------------------------------------------------------------------------
// joystick_differential_drive_mixer
// mixes joystick axes into right track, left track and flipper drive values
// ----------------------------------------------------------------------------
module joystick_differential_drive_mixer
    import jddm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [2:0]               cfg_index,
    input  logic [12:0]              cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               forward_back_axis,
    input  logic [7:0]               turn_axis,
    input  logic [7:0]               flipper_axis,
    input  logic [7:0]               speed_knob,
    input  logic                     parking,
    input  logic                     emergency_stop,
    input  logic                     flipper_hold,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [OUT_W-1:0]  right_drive,
    output logic signed [OUT_W-1:0]  left_drive,
    output logic signed [OUT_W-1:0]  flipper_drive
);

    cfg_t   cfg;
    entry_t entry, head;
    logic   q_full, q_empty, q_pop;

    assign in_ready = !q_full;

    jddm_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .forward_back_axis (forward_back_axis),
        .turn_axis         (turn_axis),
        .flipper_axis      (flipper_axis),
        .speed_knob        (speed_knob),
        .parking           (parking),
        .emergency_stop    (emergency_stop),
        .flipper_hold      (flipper_hold),
        .cfg               (cfg),
        .entry             (entry)
    );

    jddm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .push_data (entry),
        .pop       (q_pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    jddm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_empty       (q_empty),
        .q_head        (head),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .right_drive   (right_drive),
        .left_drive    (left_drive),
        .flipper_drive (flipper_drive)
    );

endmodule

[tb/sv/tb_joystick_differential_drive_mixer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joystick_differential_drive_mixer
// drives joystick items through several register settings and idle and stall patterns,
// predicts the track and flipper drive values per item and checks each result
// ----------------------------------------------------------------------------
module tb_joystick_differential_drive_mixer;
    import jddm_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 190;

    typedef struct packed {
        logic [7:0] fb;
        logic [7:0] tn;
        logic [7:0] fl;
        logic [7:0] knob;
        logic       park;
        logic       estop;
        logic       flock;
    } stick_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] right;
        logic signed [OUT_W-1:0] left;
        logic signed [OUT_W-1:0] flip;
    } drive_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [12:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [7:0] forward_back_axis;
    logic [7:0] turn_axis;
    logic [7:0] flipper_axis;
    logic [7:0] speed_knob;
    logic parking;
    logic emergency_stop;
    logic flipper_hold;
    logic out_valid;
    logic out_ready;
    logic signed [OUT_W-1:0] right_drive;
    logic signed [OUT_W-1:0] left_drive;
    logic signed [OUT_W-1:0] flipper_drive;

    cfg_t   mix_cfg;
    stick_t stick_q[$];
    drive_t drive_q[$];
    stick_t cur_stick;
    int     err_cnt;
    int     cycles;
    int     idle_pct;
    int     stall_pct;

    joystick_differential_drive_mixer dut (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint nz(logic [7:0] d);
        return (d == 8'd0) ? 1 : longint'(d);
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [OUT_W-1:0] scale(longint v, longint k);
        longint s;
        s = (v * k) / nz(mix_cfg.max_scalar);
        s = s * longint'(mix_cfg.speed_gain);
        if (s > 1048575)
            s = 1048575;
        if (s < -1048576)
            s = -1048576;
        return s[OUT_W-1:0];
    endfunction

    function automatic drive_t mix_drive(stick_t it);
        longint y, x, z, k, zp, db, tl, tr, sl, sr, sf, t;
        bit yc;
        drive_t d;
        y = it.fb;
        x = it.tn;
        z = it.fl;
        k = it.knob;
        zp = mix_cfg.zero_point;
        db = mix_cfg.dead_band;
        tl = 0;
        tr = 0;
        sl = 0;
        sr = 0;
        sf = 0;
        if (it.flock)
            z = FORCED_CENTRE;
        if (it.park || it.estop)
        begin
            x = FORCED_CENTRE;
            y = FORCED_CENTRE;
        end
        yc = mag(y - zp) <= db;
        if (x > zp + db)
        begin
            tl = (x - zp) / nz(mix_cfg.turn_divisor);
            if (yc)
            begin
                t = (tl > SPIN_CAP) ? longint'(SPIN_CAP) : tl;
                t = t / nz(mix_cfg.spin_divisor);
                sl = t;
                sr = -t;
            end
        end
        else if (x < zp - db)
        begin
            tr = (zp - x) / nz(mix_cfg.turn_divisor);
            if (yc)
            begin
                t = (tr > SPIN_CAP) ? longint'(SPIN_CAP) : tr;
                t = t / nz(mix_cfg.spin_divisor);
                sl = -t;
                sr = t;
            end
        end
        if (y < zp - db)
        begin
            sl = -mag((zp - y) - tl);
            sr = -mag((zp - y) - tr);
        end
        else if (y > zp + db)
        begin
            sl = mag((y - zp) - tl);
            sr = mag((y - zp) - tr);
        end
        if (z > zp + db || z < zp - db)
            sf = z - zp;
        if (k < longint'(mix_cfg.min_scalar))
            k = mix_cfg.min_scalar;
        if (k > longint'(mix_cfg.max_scalar))
            k = mix_cfg.max_scalar;
        d.right = scale(sr, k);
        d.left = scale(-sl, k);
        d.flip = scale(sf, k);
        return d;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            {forward_back_axis, turn_axis, flipper_axis, speed_knob} <= '0;
            {parking, emergency_stop, flipper_hold} <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                drive_q.push_back(mix_drive(cur_stick));
            if (!in_valid || in_ready)
            begin
                if (stick_q.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    cur_stick = stick_q.pop_front();
                    in_valid <= 1'b1;
                    forward_back_axis <= cur_stick.fb;
                    turn_axis <= cur_stick.tn;
                    flipper_axis <= cur_stick.fl;
                    speed_knob <= cur_stick.knob;
                    parking <= cur_stick.park;
                    emergency_stop <= cur_stick.estop;
                    flipper_hold <= cur_stick.flock;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (drive_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected item: r=%0d l=%0d f=%0d",
                                 right_drive, left_drive, flipper_drive);
                end
                else
                begin
                    drive_t e;
                    e = drive_q.pop_front();
                    if (e.right !== right_drive || e.left !== left_drive
                        || e.flip !== flipper_drive)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("mismatch: exp r=%0d l=%0d f=%0d got r=%0d l=%0d f=%0d",
                                     e.right, e.left, e.flip,
                                     right_drive, left_drive, flipper_drive);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [12:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ZERO_POINT:   mix_cfg.zero_point = val[7:0];
            REG_DEAD_BAND:    mix_cfg.dead_band = val[6:0];
            REG_TURN_DIVISOR: mix_cfg.turn_divisor = val[7:0];
            REG_SPIN_DIVISOR: mix_cfg.spin_divisor = val[7:0];
            REG_MIN_SCALAR:   mix_cfg.min_scalar = val[7:0];
            REG_MAX_SCALAR:   mix_cfg.max_scalar = val[7:0];
            REG_SPEED_GAIN:   mix_cfg.speed_gain = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // checked mid-cycle so that queue updates of the same edge are settled
    task automatic wait_drained();
        while (stick_q.size() > 0 || in_valid || drive_q.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic add_stick(logic [7:0] fb, logic [7:0] tn, logic [7:0] fl,
                             logic [7:0] knob, logic park, logic estop, logic flock);
        stick_q.push_back('{fb, tn, fl, knob, park, estop, flock});
    endtask

    // axis value biased around the centre and the dead band edges
    function automatic logic [7:0] near_axis();
        int v;
        case ($urandom_range(3))
            0: return 8'($urandom_range(255));
            1: v = int'(mix_cfg.zero_point) + $urandom_range(6) - 3;
            default:
            begin
                v = int'(mix_cfg.dead_band) + $urandom_range(80) - 4;
                v = int'(mix_cfg.zero_point) + (($urandom_range(1) == 1) ? v : -v);
            end
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    initial
    begin
        logic [12:0] setv[7];
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_ZERO_POINT;
        cfg_data = '0;
        err_cnt = 0;
        cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        mix_cfg = '{8'd128, 7'd10, 8'd2, 8'd1, 8'd50, 8'd255, 13'd1};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items at reset values
        add_stick(8'd128, 8'd128, 8'd128, 8'd255, 1'b0, 1'b0, 1'b0);
        add_stick(8'd255, 8'd128, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0);
        add_stick(8'd0, 8'd128, 8'd0, 8'd255, 1'b0, 1'b0, 1'b0);
        add_stick(8'd128, 8'd255, 8'd128, 8'd0, 1'b0, 1'b0, 1'b0);
        add_stick(8'd128, 8'd0, 8'd128, 8'd100, 1'b0, 1'b0, 1'b0);
        add_stick(8'd130, 8'd180, 8'd140, 8'd200, 1'b0, 1'b0, 1'b0);
        add_stick(8'd200, 8'd255, 8'd60, 8'd255, 1'b0, 1'b0, 1'b0);
        add_stick(8'd200, 8'd0, 8'd60, 8'd255, 1'b0, 1'b0, 1'b0);
        add_stick(8'd20, 8'd255, 8'd200, 8'd128, 1'b0, 1'b0, 1'b0);
        add_stick(8'd20, 8'd0, 8'd200, 8'd128, 1'b0, 1'b0, 1'b0);
        add_stick(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0);
        add_stick(8'd0, 8'd0, 8'd0, 8'd255, 1'b0, 1'b1, 1'b0);
        add_stick(8'd0, 8'd255, 8'd0, 8'd255, 1'b0, 1'b0, 1'b1);
        add_stick(8'd255, 8'd0, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1);
        add_stick(8'd138, 8'd139, 8'd117, 8'd49, 1'b0, 1'b0, 1'b0);
        add_stick(8'd139, 8'd117, 8'd139, 8'd51, 1'b0, 1'b0, 1'b0);
        wait_drained();

        // forced centre with a shifted zero point, unknown register ignored
        cfg_write(REG_ZERO_POINT, 13'd20);
        cfg_write(REG_UNUSED, 13'h1FFF);
        add_stick(8'd20, 8'd20, 8'd20, 8'd255, 1'b1, 1'b0, 1'b1);
        add_stick(8'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 1'b0);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: setv = '{128, 10, 2, 1, 50, 255, 4096};
                1: setv = '{0, 0, 0, 0, 0, 0, 8191};
                2: setv = '{255, 127, 255, 255, 255, 1, 1};
                3: setv = '{128, 5, 1, 3, 200, 100, 300};
                4: setv = '{100, 20, 4, 2, 1, 255, 0};
                default:
                begin
                    setv[0] = 13'($urandom_range(255));
                    setv[1] = 13'($urandom_range(127));
                    setv[2] = 13'($urandom_range(255));
                    setv[3] = 13'($urandom_range(255));
                    setv[4] = 13'($urandom_range(255));
                    setv[5] = 13'($urandom_range(255));
                    setv[6] = 13'($urandom_range(8191));
                end
            endcase
            cfg_write(REG_ZERO_POINT, setv[0]);
            cfg_write(REG_DEAD_BAND, setv[1]);
            cfg_write(REG_TURN_DIVISOR, setv[2]);
            cfg_write(REG_SPIN_DIVISOR, setv[3]);
            cfg_write(REG_MIN_SCALAR, setv[4]);
            cfg_write(REG_MAX_SCALAR, setv[5]);
            cfg_write(REG_SPEED_GAIN, setv[6]);
            case (p % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 83;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 83;
                end
                default:
                begin
                    idle_pct = 37;
                    stall_pct = 37;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2 && p == 3)
                begin
                    // sender holds off until the pipeline is empty
                    while (stick_q.size() > 0 || in_valid || drive_q.size() > 0)
                        @(negedge clk);
                end
                add_stick(near_axis(), near_axis(), near_axis(),
                          8'($urandom_range(255)),
                          $urandom_range(7) == 0, $urandom_range(7) == 0,
                          $urandom_range(5) == 0);
                if (stick_q.size() > 8)
                    @(posedge clk);
            end
            wait_drained();
        end

        if (err_cnt == 0 && drive_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/jddm_pkg.sv
rtl/core/jddm_div.sv
rtl/core/jddm_front.sv
rtl/core/jddm_queue.sv
rtl/core/jddm_back.sv
rtl/core/joystick_differential_drive_mixer.sv
tb/sv/tb_joystick_differential_drive_mixer.sv
